// ----- rtl/bsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared constants, types and fixed-point helpers of the Brusselator
// stencil right-hand-side unit.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int GridSize  = 16;
  localparam int RowLen    = 2 * GridSize;
  localparam int GridTotal = 2 * GridSize * GridSize;
  localparam int WinDepth  = 4 * GridSize + 1;

  localparam int POS_W  = $clog2(GridTotal);
  localparam int RC_W   = $clog2(GridSize);
  localparam int ADDR_W = $clog2(WinDepth);
  localparam int IDX_W  = 9;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 31;
  localparam int PROD_W = 66;
  localparam int R_W    = PROD_W - 16;

  localparam logic [1:0] CfgGain  = 2'd0;
  localparam logic [1:0] CfgFeedA = 2'd1;
  localparam logic [1:0] CfgRateB = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] dn;
    logic signed [DATA_W-1:0] lf;
    logic signed [DATA_W-1:0] rt;
    logic signed [DATA_W-1:0] pt;
    logic                     odd;
  } bsr_opnd_t;

  typedef struct packed {
    logic [CFG_W-1:0] gain;
    logic [CFG_W-1:0] feed_a;
    logic [CFG_W-1:0] rate_b;
  } bsr_cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_EMIT
  } bsr_state_e;

  typedef enum logic [3:0] {
    C_IDLE,
    C_LAP,
    C_MG,
    C_MUU,
    C_UU,
    C_MUUV,
    C_MB,
    C_SUM
  } bsr_calc_e;

  // round to Q16.16: add half, floor-divide by 2^16
  function automatic logic signed [R_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return R_W'(t >>> 16);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [R_W-1:0] v);
    logic signed [R_W-1:0] hi;
    logic signed [R_W-1:0] lo;
    hi = R_W'(64'sh7FFF_FFFF);
    lo = -R_W'(64'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return DATA_W'(v);
  endfunction

endpackage

// ----- rtl/brusselator_2d_stencil_rhs_unit.sv -----
// ----------------------------------------------------------------------------
// brusselator_2d_stencil_rhs_unit
// Streaming 5-point stencil right-hand side of a 2D Brusselator grid.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the grid state as signed Q16.16 samples on sample_value_i, U then V
//   per cell, row major; a transaction completes when valid is high and
//   stall is low. Each sample from the second grid row on yields the
//   derivative of the component one row above; the last sample of a grid
//   also yields the whole bottom row (2*N+1 results in all) and the position wraps.
//   Samples live in a circular line memory of 4*N+1 entries. Each result
//   takes 6 single-port reads, then arithmetic through one shared
//   multiplier, then a load of the output register; the sample itself is
//   written to the line memory when it is accepted.
//   sample_stall_o is high while results of the last sample are in work.
//   The output register holds a result while deriv_stall_i is high; the
//   sequencer waits for it to drain. Reset clears the grid position, the
//   handshake state and loads the default gain, feed and rate values.
//   Configuration writes are taken at any edge with cfg_we_i high.
// ----------------------------------------------------------------------------
module brusselator_2d_stencil_rhs_unit import bsr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     sample_valid_i,
  output logic                     sample_stall_o,
  input  logic signed [DATA_W-1:0] sample_value_i,
  output logic                     deriv_valid_o,
  input  logic                     deriv_stall_i,
  output logic signed [DATA_W-1:0] deriv_value_o,
  output logic [IDX_W-1:0]         component_index_o,
  output logic                     grid_done_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i
);

  bsr_state_e state_q, state_d;
  bsr_cfg_t   cfg_q;

  logic [POS_W-1:0]  pos_q, c_q, last_q;
  logic [RC_W-1:0]   prow_q, pcol_q, crow_q, ccol_q;
  logic [ADDR_W-1:0] wp_q, ca_q;
  logic [2:0]        rd_cnt_q;
  logic              go_q;
  logic signed [DATA_W-1:0] opnd_q [6];
  logic              out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_done_q;

  logic              accept, slot_free, ram_we, calc_done;
  logic [ADDR_W-1:0] ram_addr, rd_addr;
  logic [DATA_W-1:0] ram_rdata;
  logic signed [DATA_W-1:0] calc_res;
  logic signed [ADDR_W+1:0] off;
  bsr_opnd_t         opnd;

  function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                  input logic signed [ADDR_W+1:0] o);
    logic signed [ADDR_W+1:0] s;
    s = $signed({2'b00, a}) + o;
    if (s < 0) s = s + (ADDR_W+2)'(WinDepth);
    else if (s >= (ADDR_W+2)'(WinDepth)) s = s - (ADDR_W+2)'(WinDepth);
    return s[ADDR_W-1:0];
  endfunction

  assign accept    = sample_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !deriv_stall_i;

  // neighbour offsets, mirrored at the grid edge
  always_comb begin
    case (rd_cnt_q)
      3'd1:    off = (crow_q != '0) ? -(ADDR_W+2)'(RowLen) : (ADDR_W+2)'(RowLen);
      3'd2:    off = (crow_q != RC_W'(GridSize-1)) ? (ADDR_W+2)'(RowLen)
                                                   : -(ADDR_W+2)'(RowLen);
      3'd3:    off = (ccol_q != '0) ? -(ADDR_W+2)'(2) : (ADDR_W+2)'(2);
      3'd4:    off = (ccol_q != RC_W'(GridSize-1)) ? (ADDR_W+2)'(2) : -(ADDR_W+2)'(2);
      3'd5:    off = c_q[0] ? -(ADDR_W+2)'(1) : (ADDR_W+2)'(1);
      default: off = '0;
    endcase
  end

  assign rd_addr  = addr_add(ca_q, off);
  assign ram_we   = accept;
  assign ram_addr = accept ? wp_q : rd_addr;

  bsr_ram #(.WIDTH(DATA_W), .DEPTH(WinDepth)) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (sample_value_i),
    .rdata_o (ram_rdata)
  );

  assign opnd.x   = opnd_q[0];
  assign opnd.up  = opnd_q[1];
  assign opnd.dn  = opnd_q[2];
  assign opnd.lf  = opnd_q[3];
  assign opnd.rt  = opnd_q[4];
  assign opnd.pt  = opnd_q[5];
  assign opnd.odd = c_q[0];

  bsr_calc u_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (go_q),
    .opnd_i   (opnd),
    .cfg_i    (cfg_q),
    .done_o   (calc_done),
    .result_o (calc_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept && prow_q != '0) state_d = S_READ;
      S_READ:  if (rd_cnt_q == 3'd6) state_d = S_CALC;
      S_CALC:  if (calc_done) state_d = S_EMIT;
      S_EMIT:  if (slot_free) state_d = (c_q == last_q) ? S_IDLE : S_READ;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      prow_q      <= '0;
      pcol_q      <= '0;
      wp_q        <= '0;
      rd_cnt_q    <= '0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q.gain   <= CFG_W'(29491);
      cfg_q.feed_a <= CFG_W'(65536);
      cfg_q.rate_b <= CFG_W'(222822);
    end else begin
      state_q <= state_d;
      go_q    <= (state_q == S_READ) && (rd_cnt_q == 3'd6);

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGain:  cfg_q.gain   <= cfg_wdata_i;
          CfgFeedA: cfg_q.feed_a <= cfg_wdata_i;
          CfgRateB: cfg_q.rate_b <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (accept) begin
        wp_q <= addr_add(wp_q, (ADDR_W+2)'(1));
        if (pos_q == POS_W'(GridTotal-1)) begin
          pos_q  <= '0;
          prow_q <= '0;
          pcol_q <= '0;
        end else begin
          pos_q <= pos_q + POS_W'(1);
          if (pos_q[0]) begin
            if (pcol_q == RC_W'(GridSize-1)) begin
              pcol_q <= '0;
              prow_q <= prow_q + RC_W'(1);
            end else begin
              pcol_q <= pcol_q + RC_W'(1);
            end
          end
        end
      end

      if (state_q == S_READ) rd_cnt_q <= rd_cnt_q + 3'd1;
      else rd_cnt_q <= '0;

      out_valid_q <= (state_q == S_EMIT && slot_free) || (out_valid_q && deriv_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q    <= pos_q - POS_W'(RowLen);
      crow_q <= prow_q - RC_W'(1);
      ccol_q <= pcol_q;
      ca_q   <= addr_add(wp_q, -(ADDR_W+2)'(RowLen));
      last_q <= (pos_q == POS_W'(GridTotal-1)) ? pos_q : pos_q - POS_W'(RowLen);
    end
    if (state_q == S_READ && rd_cnt_q != 3'd0) begin
      opnd_q[rd_cnt_q - 3'd1] <= ram_rdata;
    end
    if (state_q == S_EMIT && slot_free) begin
      out_value_q <= calc_res;
      out_idx_q   <= IDX_W'(c_q);
      out_done_q  <= (c_q == POS_W'(GridTotal-1));
      // advance to the next component of the burst
      c_q  <= c_q + POS_W'(1);
      ca_q <= addr_add(ca_q, (ADDR_W+2)'(1));
      if (c_q[0]) begin
        if (ccol_q == RC_W'(GridSize-1)) begin
          ccol_q <= '0;
          crow_q <= crow_q + RC_W'(1);
        end else begin
          ccol_q <= ccol_q + RC_W'(1);
        end
      end
    end
  end

  assign sample_stall_o    = (state_q != S_IDLE);
  assign deriv_valid_o     = out_valid_q;
  assign deriv_value_o     = out_value_q;
  assign component_index_o = out_idx_q;
  assign grid_done_o       = out_done_q;

endmodule

// ----- rtl/bsr_ram.sv -----
// ----------------------------------------------------------------------------
// bsr_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- rtl/bsr_calc.sv -----
// ----------------------------------------------------------------------------
// bsr_calc
// Multi-cycle arithmetic for one derivative: Laplacian from adds and a shift,
// then diffusion and reaction terms through one shared multiplier.
// ----------------------------------------------------------------------------
module bsr_calc import bsr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  bsr_opnd_t                opnd_i,
  input  bsr_cfg_t                 cfg_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] result_o
);

  bsr_calc_e state_q, state_d;

  logic signed [DATA_W-1:0] lap_q, uu_q, res_q;
  logic signed [R_W-1:0]    diff_q, uuv_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [32:0]       ma, mb;
  logic signed [DATA_W-1:0] u, v;
  logic signed [34:0]       lap_sum;
  logic signed [R_W-1:0]    bu, r;
  logic [DATA_W-1:0]        b_coef;

  assign u = opnd_i.odd ? opnd_i.pt : opnd_i.x;
  assign v = opnd_i.odd ? opnd_i.x : opnd_i.pt;
  assign b_coef = opnd_i.odd ? {1'b0, cfg_i.rate_b}
                             : {1'b0, cfg_i.rate_b} + DATA_W'(65536);

  assign lap_sum = 35'(opnd_i.up) + 35'(opnd_i.dn) + 35'(opnd_i.lf) + 35'(opnd_i.rt)
                 - (35'(opnd_i.x) <<< 2);

  always_comb begin
    case (state_q)
      C_MG: begin
        ma = $signed({2'b00, cfg_i.gain});
        mb = 33'(lap_q);
      end
      C_MUU: begin
        ma = 33'(u);
        mb = 33'(u);
      end
      C_MUUV: begin
        ma = 33'(uu_q);
        mb = 33'(v);
      end
      C_MB: begin
        ma = $signed({1'b0, b_coef});
        mb = 33'(u);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign bu = round_q16(prod_q);
  assign r  = opnd_i.odd ? bu - uuv_q + diff_q
                         : R_W'($signed({1'b0, cfg_i.feed_a})) + uuv_q - bu + diff_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE:  if (start_i) state_d = C_LAP;
      C_LAP:   state_d = C_MG;
      C_MG:    state_d = C_MUU;
      C_MUU:   state_d = C_UU;
      C_UU:    state_d = C_MUUV;
      C_MUUV:  state_d = C_MB;
      C_MB:    state_d = C_SUM;
      C_SUM:   state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(ma * mb);
    case (state_q)
      C_LAP:  lap_q  <= sat32(R_W'(lap_sum));
      C_MUU:  diff_q <= round_q16(prod_q);
      C_UU:   uu_q   <= sat32(round_q16(prod_q));
      C_MB:   uuv_q  <= round_q16(prod_q);
      C_SUM:  res_q  <= sat32(r);
      default: ;
    endcase
  end

  // hold the last result until the next derivative completes
  assign done_o   = (state_q == C_SUM);
  assign result_o = res_q;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Streams Brusselator grid samples through the stencil unit and compares each
// derivative against an in-bench fixed-point predictor, across several
// coefficient settings, with random idling on both channels and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import bsr_pkg::*;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int NUM_ITEMS = 310;
  localparam int SEG_LEN = 100;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         idx;
    logic                     done;
  } deriv_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [5:0]               n_res;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     sample_valid_i = 1'b0;
  logic                     sample_stall_o;
  logic signed [DATA_W-1:0] sample_value_i = '0;
  logic                     deriv_valid_o;
  logic                     deriv_stall_i = 1'b0;
  logic signed [DATA_W-1:0] deriv_value_o;
  logic [IDX_W-1:0]         component_index_o;
  logic                     grid_done_o;
  logic                     cfg_we_i = 1'b0;
  logic [1:0]               cfg_idx_i = CfgGain;
  logic [CFG_W-1:0]         cfg_wdata_i = '0;

  brusselator_2d_stencil_rhs_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [DATA_W-1:0] window_q [WinDepth];
  int unsigned              grid_pos = 0;
  logic [CFG_W-1:0]         gain_r = 31'd29491;
  logic [CFG_W-1:0]         feed_r = 31'd65536;
  logic [CFG_W-1:0]         rate_r = 31'd222822;

  deriv_t deriv_q[$];
  int     err_cnt = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_settings = 1;
  bit     quiet = 1'b0;
  bit     hold = 1'b0;

  function automatic longint q16_round(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint tap(int unsigned p, int unsigned q);
    return longint'(window_q[p - q]);
  endfunction

  function automatic deriv_t derive(int unsigned p, int unsigned c);
    int unsigned row, col;
    longint x, up, dn, lf, rt, lap, diff, u, v, uu, uuv, r, g, a, b;
    deriv_t d;
    row = c / RowLen;
    col = (c % RowLen) / 2;
    g = longint'(gain_r);
    a = longint'(feed_r);
    b = longint'(rate_r);
    x = tap(p, c);
    up = (row > 0) ? tap(p, c - RowLen) : tap(p, c + RowLen);
    dn = (row < GridSize - 1) ? tap(p, c + RowLen) : tap(p, c - RowLen);
    lf = (col > 0) ? tap(p, c - 2) : tap(p, c + 2);
    rt = (col < GridSize - 1) ? tap(p, c + 2) : tap(p, c - 2);
    lap = clip32(up + dn + lf + rt - 4 * x);
    diff = q16_round(g * lap);
    if (c[0] == 1'b0) begin
      u = x;
      v = tap(p, c + 1);
    end else begin
      u = tap(p, c - 1);
      v = x;
    end
    uu = clip32(q16_round(u * u));
    uuv = q16_round(uu * v);
    if (c[0] == 1'b0) r = a + uuv - q16_round((b + 65536) * u) + diff;
    else r = q16_round(b * u) - uuv + diff;
    d.value = DATA_W'(clip32(r));
    d.idx = IDX_W'(c);
    d.done = (c == GridTotal - 1);
    return d;
  endfunction

  // shift in one sample and queue the derivatives it completes
  function automatic int absorb_sample(logic signed [DATA_W-1:0] s);
    int unsigned p;
    int n;
    n = 0;
    for (int i = WinDepth - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = s;
    if (grid_pos >= GridTotal) grid_pos = 0;
    p = grid_pos;
    if (p >= RowLen) begin
      deriv_q.push_back(derive(p, p - RowLen));
      n++;
    end
    if (p == GridTotal - 1) begin
      for (int unsigned c = GridTotal - RowLen; c < GridTotal; c++) begin
        deriv_q.push_back(derive(p, c));
        n++;
      end
      grid_pos = 0;
    end else begin
      grid_pos = p + 1;
    end
    return n;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return DATA_W'($signed($urandom_range(655360)) - 327680);
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return DATA_W'($urandom_range(262144));
    endcase
  endfunction

  task automatic send_sample(input logic signed [DATA_W-1:0] s, output int n);
    if (!quiet && $urandom_range(99) < 9) begin
      sample_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_value_i <= s;
    do @(posedge clk_i); while (sample_stall_o);
    n = absorb_sample(s);
    n_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgGain:  gain_r = val;
      CfgFeedA: feed_r = val;
      CfgRateB: rate_r = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    sample_valid_i <= 1'b0;
    wait (deriv_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // receiver: random stall, one long hold-off
  always @(posedge clk_i) begin
    deriv_stall_i <= hold ? 1'b1 : (quiet ? 1'b0 : ($urandom_range(99) < 9));
  end

  initial begin
    wait (n_sent >= 230);
    hold = 1'b1;
    repeat (400) @(posedge clk_i);
    hold = 1'b0;
  end

  always @(posedge clk_i) begin
    deriv_t e;
    if (rst_ni && deriv_valid_o && !deriv_stall_i) begin
      if (deriv_q.size() == 0) begin
        $error("unexpected derivative idx=%0d value=%0d", component_index_o, deriv_value_o);
        err_cnt++;
      end else begin
        e = deriv_q.pop_front();
        n_checked++;
        if (deriv_value_o !== e.value) begin
          $error("deriv_value: expected %0d, got %0d", e.value, deriv_value_o);
          err_cnt++;
        end
        if (component_index_o !== e.idx) begin
          $error("component_index: expected %0d, got %0d", e.idx, component_index_o);
          err_cnt++;
        end
        if (grid_done_o !== e.done) begin
          $error("grid_done: expected %0d, got %0d", e.done, grid_done_o);
          err_cnt++;
        end
      end
    end
  end

  // first row: no derivative until the row below arrives
  stim_row_t directed [25] = '{
    '{32'sh7FFF_FFFF, 6'd0}, '{32'sh8000_0000, 6'd0}, '{32'sh0000_0000, 6'd0},
    '{32'shFFFF_FFFF, 6'd0}, '{32'sh0000_0001, 6'd0}, '{32'sh0001_0000, 6'd0},
    '{32'shFFFF_0000, 6'd0}, '{32'sh0004_6666, 6'd0}, '{32'sh0003_6666, 6'd0},
    '{32'sh0000_8000, 6'd0}, '{32'shFFFF_8000, 6'd0}, '{32'sh5555_5555, 6'd0},
    '{32'shAAAA_AAAA, 6'd0}, '{32'sh7FFF_FFFF, 6'd0}, '{32'sh7FFF_FFFF, 6'd0},
    '{32'sh8000_0000, 6'd0}, '{32'sh8000_0000, 6'd0}, '{32'sh0002_0000, 6'd0},
    '{32'sh0000_FFFF, 6'd0}, '{32'sh0001_0001, 6'd0}, '{32'sh0000_0000, 6'd0},
    '{32'sh0000_0000, 6'd0}, '{32'sh0100_0000, 6'd0}, '{32'shFF00_0000, 6'd0},
    '{32'sh0000_7FFF, 6'd0}
  };

  initial begin
    int n;
    int seg_end;
    for (int i = 0; i < WinDepth; i++) window_q[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_sample(directed[i].value, n);
      if (n != directed[i].n_res) begin
        $error("row %0d: expected %0d derivatives, predicted %0d", i, directed[i].n_res, n);
        err_cnt++;
      end
    end

    for (int g = 0; g < 3; g++) begin
      seg_end = (g == 2) ? NUM_ITEMS : SEG_LEN * (g + 1);
      if (g == 1) begin
        drain();
        write_reg(CfgGain, 31'h7FFF_FFFF);
        write_reg(CfgFeedA, 31'h7FFF_FFFF);
        write_reg(CfgRateB, 31'h7FFF_FFFF);
        n_settings++;
      end else if (g == 2) begin
        drain();
        write_reg(CfgGain, '0);
        write_reg(CfgFeedA, '0);
        write_reg(CfgRateB, '0);
        write_reg(CfgUnused, 31'h1234_5678);
        write_reg(CfgGain, CFG_W'($urandom_range(131072)));
        write_reg(CfgRateB, CFG_W'($urandom_range(327680)));
        n_settings++;
      end
      while (n_sent < seg_end) begin
        quiet = (g == 1 && n_sent >= 120 && n_sent < 190);
        send_sample(pick_sample(), n);
      end
    end
    quiet = 1'b0;
    drain();

    $display("Streamed %0d samples over the first rows and interior of a grid,", n_sent);
    $display("checked %0d derivatives under %0d coefficient settings.",
             n_checked, n_settings);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
